FILE: hdl/csg_pkg.sv
// shared types and constants for the centre spiral scan generator
package csg_pkg;

	localparam int GRID_W  = 9;
	localparam int COORD_W = 8;
	localparam int VALUE_W = 16;

	localparam logic [GRID_W-1:0] GRID_SIDE_RST = 9'd4;

	typedef enum logic [1:0] {
		HEAD_RIGHT,
		HEAD_DOWN,
		HEAD_LEFT,
		HEAD_UP
	} csg_heading_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [VALUE_W-1:0] order_value;
		logic               last;
	} csg_result_t;

endpackage

FILE: hdl/center_spiral_scan_generator_top.sv
// top level of the centre spiral scan generator
//
// usage
//   - input channel in_valid / in_ready carries one request with field restart:
//     restart = 1 puts the walk on the centre cell and reports it with value 0,
//     restart = 0 moves one step round the square spiral (right, down, left, up,
//     leg lengths 1,1,2,2,3,3 ...)
//   - output channel out_valid / out_ready carries row, col, order_value, last;
//     a step that lands outside the grid, an advance before the first restart and
//     any advance after the last cell give no output
//   - cfg_wr_en / cfg_wr_data write the grid side; zero acts as one and values
//     above MAX_SIDE are clamped; write only while the block is idle
//   - a request accepted on the input channel passes the input stage, then the
//     result register, before out_valid rises and the result can be taken
//   - one request per cycle sustained while out_ready stays high: the walk state
//     is registered on each step, so the spiral position feeds straight back into the next request
//   - a stalled receiver holds the result register; one more request may sit in
//     the input stage, after which in_ready drops until out_ready returns
//   - reset clears both stages, leaves the walk not started and sets side 4
module center_spiral_scan_generator_top
	import csg_pkg::*;
#(
	parameter int MAX_SIDE = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [GRID_W-1:0]  cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COORD_W-1:0] row,
	output logic [COORD_W-1:0] col,
	output logic [VALUE_W-1:0] order_value,
	output logic               last
);

	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int CW = $clog2(MAX_SIDE * MAX_SIDE + 1);

	logic [SW-1:0] side;
	logic [CW-1:0] total;

	// input stage
	logic valid_s1;
	logic restart_s1;
	logic advance;

	// walker result and output register
	logic        emit;
	csg_result_t result;
	logic        out_valid_q;
	csg_result_t out_q;

	csg_cfg #(
		.MAX_SIDE(MAX_SIDE),
		.SW      (SW),
		.CW      (CW)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.wr_data(cfg_wr_data),
		.side   (side),
		.total  (total)
	);

	// the staged request is processed once the result register can take it
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			restart_s1 <= restart;
		end
	end

	csg_walk #(
		.MAX_SIDE(MAX_SIDE),
		.SW      (SW),
		.CW      (CW)
	) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.restart(restart_s1),
		.side   (side),
		.total  (total),
		.emit   (emit),
		.result (result)
	);

	// result register, refilled in the same cycle it is drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign row         = out_q.row;
	assign col         = out_q.col;
	assign order_value = out_q.order_value;
	assign last        = out_q.last;

	// the input stage holds its request while the result register is blocked
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(restart_s1))
		else $error("input stage lost a waiting request");

	// back-pressure only comes from a stalled, full result register
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid_q && !out_ready)
		else $error("in_ready low without a stalled result");

	// a processed restart always shows up as the centre cell with value zero
	a_restart_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance && restart_s1 |=> out_valid && order_value == '0)
		else $error("restart did not produce the centre cell");

endmodule

FILE: hdl/csg_cfg.sv
// grid side register with clamped side and cell total
module csg_cfg
	import csg_pkg::*;
#(
	parameter int MAX_SIDE = 256,
	parameter int SW = $clog2(MAX_SIDE + 1),
	parameter int CW = $clog2(MAX_SIDE * MAX_SIDE + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [GRID_W-1:0] wr_data,
	output logic [SW-1:0]     side,
	output logic [CW-1:0]     total
);

	localparam int RST_SIDE = (int'(GRID_SIDE_RST) > MAX_SIDE) ? MAX_SIDE
		: int'(GRID_SIDE_RST);

	logic [SW-1:0] side_d;
	logic [CW-1:0] total_d;
	logic [SW-1:0] side_q;
	logic [CW-1:0] total_q;

	// zero acts as one, anything above the largest side is clamped
	always_comb begin
		priority if (wr_data == '0) begin
			side_d = SW'(1);
		end else if (32'(wr_data) > MAX_SIDE) begin
			side_d = SW'(MAX_SIDE);
		end else begin
			side_d = SW'(wr_data);
		end
		// widen before squaring so the full side squared fits
		total_d = CW'(side_d) * CW'(side_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q  <= SW'(RST_SIDE);
			total_q <= CW'(RST_SIDE * RST_SIDE);
		end else if (wr_en) begin
			side_q  <= side_d;
			total_q <= total_d;
		end
	end

	assign side  = side_q;
	assign total = total_q;

endmodule

FILE: hdl/csg_walk.sv
// spiral walk state, one step per request, result formatting
module csg_walk
	import csg_pkg::*;
#(
	parameter int MAX_SIDE = 256,
	parameter int SW = $clog2(MAX_SIDE + 1),
	parameter int CW = $clog2(MAX_SIDE * MAX_SIDE + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          restart,
	input  logic [SW-1:0] side,
	input  logic [CW-1:0] total,
	output logic          emit,
	output csg_result_t   result
);

	localparam int PW = SW + 2;
	localparam int LW = SW + 1;

	logic signed [PW-1:0] row_q, col_q;
	csg_heading_t         heading_q;
	logic [LW-1:0]        leg_len_q, leg_prog_q;
	logic                 second_leg_q;
	logic [CW-1:0]        cells_q;

	logic signed [PW-1:0] centre;
	logic signed [PW-1:0] row_nx, col_nx;
	logic signed [PW-1:0] side_s;
	logic [LW-1:0]        prog_inc;
	logic                 leg_done;
	csg_heading_t         heading_nx;
	logic                 active;
	logic                 in_grid;

	always_comb begin
		centre = PW'(side >> 1) - (side[0] ? PW'(0) : PW'(1));
		side_s = $signed({2'b00, side});
		active = (cells_q != '0) && (cells_q < total);

		row_nx = row_q;
		col_nx = col_q;
		unique case (heading_q)
			HEAD_RIGHT: begin
				col_nx     = col_q + PW'(1);
				heading_nx = HEAD_DOWN;
			end
			HEAD_DOWN: begin
				row_nx     = row_q + PW'(1);
				heading_nx = HEAD_LEFT;
			end
			HEAD_LEFT: begin
				col_nx     = col_q - PW'(1);
				heading_nx = HEAD_UP;
			end
			HEAD_UP: begin
				row_nx     = row_q - PW'(1);
				heading_nx = HEAD_RIGHT;
			end
			default: begin
				heading_nx = HEAD_RIGHT;
			end
		endcase

		prog_inc = leg_prog_q + LW'(1);
		leg_done = (prog_inc >= leg_len_q);
		in_grid  = (row_nx >= 0) && (row_nx < side_s) && (col_nx >= 0) && (col_nx < side_s);
	end

	always_comb begin
		if (restart) begin
			emit               = step;
			result.row         = COORD_W'(centre);
			result.col         = COORD_W'(centre);
			result.order_value = '0;
			result.last        = (total == CW'(1));
		end else begin
			emit               = step && active && in_grid;
			result.row         = COORD_W'(row_nx);
			result.col         = COORD_W'(col_nx);
			result.order_value = VALUE_W'(cells_q);
			result.last        = ({1'b0, cells_q} + (CW+1)'(1)) == {1'b0, total};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q        <= '0;
			col_q        <= '0;
			heading_q    <= HEAD_RIGHT;
			leg_len_q    <= LW'(1);
			leg_prog_q   <= '0;
			second_leg_q <= 1'b0;
			cells_q      <= '0;
		end else if (step) begin
			if (restart) begin
				row_q        <= centre;
				col_q        <= centre;
				heading_q    <= HEAD_RIGHT;
				leg_len_q    <= LW'(1);
				leg_prog_q   <= '0;
				second_leg_q <= 1'b0;
				cells_q      <= CW'(1);
			end else if (active) begin
				row_q <= row_nx;
				col_q <= col_nx;
				if (leg_done) begin
					leg_prog_q   <= '0;
					heading_q    <= heading_nx;
					second_leg_q <= !second_leg_q;
					if (second_leg_q) begin
						leg_len_q <= leg_len_q + LW'(1);
					end
				end else begin
					leg_prog_q <= prog_inc;
				end
				if (in_grid) begin
					cells_q <= cells_q + CW'(1);
				end
			end
		end
	end

	// nothing is ever emitted beyond the final cell of the grid
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !restart |-> cells_q < total)
		else $error("walk emitted a cell past the end of the grid");

	// a legal move never leaves the leg counter at or beyond the leg length
	a_leg_progress: assert property (@(posedge clk) disable iff (!arst_n)
		leg_prog_q < leg_len_q)
		else $error("leg progress ran past the leg length");

endmodule
